// File: sv/cma_pkg.sv
// ----------------------------------------------------------------------------
// cma_pkg
// Shared constants and types of the centered moving average filter.
// ----------------------------------------------------------------------------
package cma_pkg;

	localparam int MAX_WINDOW_DEF   = 64;
	localparam int SAMPLE_WIDTH_DEF = 16;

	localparam int CFG_W      = 7;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = REG_IDX_W'(0);
	localparam logic [CFG_W-1:0]     WINDOW_LENGTH_RST = CFG_W'(1);

	typedef struct packed {
		logic rd;
		logic wr;
		logic clr;
	} win_ctrl_t;

endpackage

// File: sv/cma_in_if.sv
// ----------------------------------------------------------------------------
// cma_in_if
// Input channel: one signal sample and its last flag per word.
// ----------------------------------------------------------------------------
interface cma_in_if
	import cma_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample;
	logic                           last_in;

	modport source (output valid, output sample, output last_in, input ready);
	modport sink   (input valid, input sample, input last_in, output ready);
endinterface

// File: sv/cma_out_if.sv
// ----------------------------------------------------------------------------
// cma_out_if
// Output channel: one averaged value and its last flag per word.
// ----------------------------------------------------------------------------
interface cma_out_if
	import cma_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] average;
	logic                           last_out;

	modport source (output valid, output average, output last_out, input ready);
	modport sink   (input valid, input average, input last_out, output ready);
endinterface

// File: sv/cma_apb_regs.sv
// ----------------------------------------------------------------------------
// cma_apb_regs
// APB register file holding the window length.
// ----------------------------------------------------------------------------
module cma_apb_regs
	import cma_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [CFG_W-1:0]      window_length
);
	logic [CFG_W-1:0] window_length_q;
	logic             wr_en;
	logic             sel_wl;

	assign pready        = 1'b1;
	assign sel_wl        = (paddr[APB_ADDR_W-1:2] == REG_WINDOW_LENGTH);
	assign wr_en         = psel & penable & pwrite & pready;
	assign window_length = window_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= WINDOW_LENGTH_RST;
		end else if (wr_en && sel_wl) begin
			window_length_q <= pwdata[CFG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_wl) begin
			prdata[CFG_W-1:0] = window_length_q;
		end
	end
endmodule

// File: sv/cma_window.sv
// ----------------------------------------------------------------------------
// cma_window
// Circular sample store with per-entry valid bits; invalid entries read zero.
// ----------------------------------------------------------------------------
module cma_window
	import cma_pkg::*;
#(
	parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter int PTR_W        = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
)(
	input  logic                           clk,
	input  logic                           arst_n,
	input  win_ctrl_t                      ctrl,
	input  logic [PTR_W-1:0]               rd_idx,
	input  logic [PTR_W-1:0]               wr_idx,
	input  logic signed [SAMPLE_WIDTH-1:0] wr_data,
	output logic signed [SAMPLE_WIDTH-1:0] rd_data
);
	logic signed [SAMPLE_WIDTH-1:0] mem [MAX_WINDOW];
	logic [MAX_WINDOW-1:0]          valid_q;
	logic signed [SAMPLE_WIDTH-1:0] rd_data_q;
	logic                           rd_valid_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr) begin
			mem[wr_idx] <= wr_data;
		end
		if (ctrl.rd) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (ctrl.rd) begin
				rd_valid_q <= valid_q[rd_idx];
			end
			if (ctrl.clr) begin
				valid_q <= '0;
			end else if (ctrl.wr) begin
				valid_q[wr_idx] <= 1'b1;
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;
endmodule

// File: sv/cma_divider.sv
// ----------------------------------------------------------------------------
// cma_divider
// Restoring serial divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module cma_divider
	import cma_pkg::*;
#(
	parameter int SUM_W = 23,
	parameter int K_W   = 7
)(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [SUM_W-1:0] dividend,
	input  logic [K_W-1:0]          divisor,
	output logic                    done,
	output logic signed [SUM_W-1:0] quotient
);
	localparam int CNT_W = $clog2(SUM_W + 1);

	logic [SUM_W-1:0] dvd_q;
	logic [K_W-1:0]   rem_q;
	logic [K_W-1:0]   dsr_q;
	logic             neg_q;
	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [K_W:0]     trial;
	logic             fits;

	assign trial = {rem_q, dvd_q[SUM_W-1]};
	assign fits  = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
			rem_q <= '0;
			dsr_q <= divisor;
			neg_q <= dividend[SUM_W-1];
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= K_W'(trial - {1'b0, dsr_q});
				dvd_q <= {dvd_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[K_W-1:0];
				dvd_q <= {dvd_q[SUM_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -$signed(dvd_q) : $signed(dvd_q);
endmodule

// File: sv/centered_moving_average.sv
// ----------------------------------------------------------------------------
// centered_moving_average
// Centered boxcar average of K samples with flush on the last sample.
// ----------------------------------------------------------------------------
//  channel   dir   payload                      handshake
//  in_ch     in    sample, last_in              valid/ready
//  out_ch    out   average, last_out            valid/ready
//  apb       in    window_length (offset 0x0)   psel/penable, pready high
//
// A sample that yields no output passes through the read, update and next
// states. One that yields an output also waits in the divide state for the
// serial divider and then in the output state. A last sample adds one pass
// per flush step, each from the read state on. Reset clears the valid bits
// of the store at once, so no clearing pass is needed. A stalled output
// word holds the sequencer until it is taken.
// ----------------------------------------------------------------------------
module centered_moving_average
	import cma_pkg::*;
#(
	parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	cma_in_if.sink                in_ch,
	cma_out_if.source             out_ch
);
	localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int K_W   = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W = SAMPLE_WIDTH + $clog2(MAX_WINDOW) + 1;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_READ = 6'b000010,
		S_UPD  = 6'b000100,
		S_DIV  = 6'b001000,
		S_OUT  = 6'b010000,
		S_NEXT = 6'b100000
	} state_t;

	state_t                         state_q;
	logic [CFG_W-1:0]               window_length;
	logic [K_W-1:0]                 k_q;
	logic [K_W-1:0]                 k_new;
	logic [K_W-1:0]                 ahead;
	logic [K_W-1:0]                 seen_q;
	logic [K_W-1:0]                 t_q;
	logic [PTR_W-1:0]               wp_q;
	logic [PTR_W-1:0]               wp_next;
	logic [PTR_W-1:0]               rd_idx;
	logic [K_W:0]                   wp_ext;
	logic [K_W:0]                   rd_sum;
	logic signed [SAMPLE_WIDTH-1:0] x_q;
	logic                           last_q;
	logic signed [SUM_W-1:0]        sum_q;
	logic signed [SUM_W-1:0]        sum_nxt;
	logic signed [SAMPLE_WIDTH-1:0] old_sample;
	logic                           emit;
	logic                           final_out;
	logic signed [SAMPLE_WIDTH-1:0] avg_q;
	logic                           last_out_q;
	win_ctrl_t                      win_ctrl;
	logic                           div_start;
	logic                           div_done;
	logic signed [SUM_W-1:0]        quotient;

	cma_apb_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.window_length (window_length)
	);

	cma_window #(
		.MAX_WINDOW   (MAX_WINDOW),
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.PTR_W        (PTR_W)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (win_ctrl),
		.rd_idx  (rd_idx),
		.wr_idx  (wp_q),
		.wr_data (x_q),
		.rd_data (old_sample)
	);

	cma_divider #(
		.SUM_W (SUM_W),
		.K_W   (K_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_nxt),
		.divisor  (k_q),
		.done     (div_done),
		.quotient (quotient)
	);

	always_comb begin
		priority if (window_length == '0) begin
			k_new = K_W'(1);
		end else if ({1'b0, window_length} > (CFG_W + 1)'(MAX_WINDOW)) begin
			k_new = K_W'(MAX_WINDOW);
		end else begin
			k_new = K_W'(window_length);
		end
	end

	assign ahead     = k_q - K_W'(1) - (k_q >> 1);
	assign wp_ext    = (K_W + 1)'(wp_q);
	assign rd_sum    = (wp_ext >= {1'b0, k_q}) ? (wp_ext - {1'b0, k_q})
	                 : (wp_ext + (K_W + 1)'(MAX_WINDOW) - {1'b0, k_q});
	assign rd_idx    = rd_sum[PTR_W-1:0];
	assign wp_next   = (wp_q == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_q + PTR_W'(1);
	assign sum_nxt   = sum_q - SUM_W'(old_sample) + SUM_W'(x_q);
	assign emit      = (({1'b0, seen_q} + {1'b0, t_q}) >= {1'b0, ahead});
	assign final_out = last_q && (t_q == ahead);

	assign win_ctrl.rd  = (state_q == S_READ);
	assign win_ctrl.wr  = (state_q == S_UPD);
	assign win_ctrl.clr = (state_q == S_NEXT) && final_out;
	assign div_start    = (state_q == S_UPD) && emit;

	assign in_ch.ready     = (state_q == S_IDLE);
	assign out_ch.valid    = (state_q == S_OUT);
	assign out_ch.average  = avg_q;
	assign out_ch.last_out = last_out_q;

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			x_q    <= in_ch.sample;
			last_q <= in_ch.last_in;
		end else if ((state_q == S_NEXT) && last_q && !final_out) begin
			x_q <= '0;
		end
		if ((state_q == S_DIV) && div_done) begin
			avg_q      <= quotient[SAMPLE_WIDTH-1:0];
			last_out_q <= final_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= K_W'(1);
			seen_q  <= '0;
			t_q     <= '0;
			wp_q    <= '0;
			sum_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						if (seen_q == '0) begin
							k_q <= k_new;
						end
						t_q     <= '0;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					sum_q   <= sum_nxt;
					wp_q    <= wp_next;
					state_q <= emit ? S_DIV : S_NEXT;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_ch.ready) begin
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					priority if (final_out) begin
						sum_q   <= '0;
						seen_q  <= '0;
						wp_q    <= '0;
						state_q <= S_IDLE;
					end else if (last_q) begin
						t_q     <= t_q + K_W'(1);
						state_q <= S_READ;
					end else begin
						if (seen_q != '1) begin
							seen_q <= seen_q + K_W'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
